// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescaper: result kinds, the command that the
// parser front end hands to the output sequencer, and the queue status group.
// No dependencies.
`default_nettype none

package jsu_pkg;

   localparam int JSU_QUEUE_DEPTH = 4;

   localparam logic [1:0] JSU_KIND_DATA  = 2'd0;
   localparam logic [1:0] JSU_KIND_DONE  = 2'd1;
   localparam logic [1:0] JSU_KIND_ERROR = 2'd2;

   // An accepted byte turns into at most one command of one to three results.
   typedef struct packed {
      logic [1:0]      count;
      logic [1:0]      kind;
      logic [2:0][7:0] data;
   } jsu_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_qstat_type;

endpackage

`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Parser front end: tracks the string state, classifies each accepted byte
// and builds the result command, including UTF-8 encoding of \u escapes.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front
   import jsu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  in_byte,
   input  wire logic        stream_end,
   output logic             cmd_push,
   output jsu_cmd_type      cmd
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [11:0] code_ff, code_in;
   jsu_cmd_type cmd_c;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   // Bit 4 set marks a byte that is not a hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h61 + 8'd10);
      else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h41 + 8'd10);
      return r;
   endfunction

   logic [4:0]  hex_c;
   logic [15:0] code_full;

   assign hex_c     = hex_val(in_byte);
   assign code_full = {code_ff, hex_c[3:0]};

   always_comb begin
      mode_in    = mode_ff;
      hex_cnt_in = hex_cnt_ff;
      code_in    = code_ff;
      cmd_c      = '{count: 2'd0, kind: JSU_KIND_DATA, data: '0};

      if (mode_ff == MODE_IDLE) begin
         if (!stream_end && !is_ws(in_byte)) begin
            if (in_byte == 8'h22) begin
               mode_in = MODE_STR;
            end else begin
               cmd_c.count = 2'd1;
               cmd_c.kind  = JSU_KIND_ERROR;
            end
         end
      end else if (stream_end) begin
         mode_in     = MODE_IDLE;
         cmd_c.count = 2'd1;
         cmd_c.kind  = JSU_KIND_ERROR;
      end else begin
         case (mode_ff)
            MODE_STR: begin
               if (in_byte == 8'h22) begin
                  mode_in     = MODE_IDLE;
                  cmd_c.count = 2'd1;
                  cmd_c.kind  = JSU_KIND_DONE;
               end else if (in_byte == 8'h5C) begin
                  mode_in = MODE_ESC;
               end else begin
                  cmd_c.count   = 2'd1;
                  cmd_c.data[0] = in_byte;
               end
            end
            MODE_ESC: begin
               mode_in     = MODE_STR;
               cmd_c.count = 2'd1;
               case (in_byte)
                  8'h22, 8'h5C, 8'h2F: cmd_c.data[0] = in_byte;
                  8'h6E: cmd_c.data[0] = 8'h0A;
                  8'h72: cmd_c.data[0] = 8'h0D;
                  8'h74: cmd_c.data[0] = 8'h09;
                  8'h75: begin
                     mode_in     = MODE_HEX;
                     hex_cnt_in  = 2'd0;
                     code_in     = '0;
                     cmd_c.count = 2'd0;
                  end
                  default: begin
                     mode_in    = MODE_IDLE;
                     cmd_c.kind = JSU_KIND_ERROR;
                  end
               endcase
            end
            MODE_HEX: begin
               if (hex_c[4]) begin
                  mode_in     = MODE_IDLE;
                  cmd_c.count = 2'd1;
                  cmd_c.kind  = JSU_KIND_ERROR;
               end else if (hex_cnt_ff != 2'd3) begin
                  code_in    = {code_ff[7:0], hex_c[3:0]};
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end else begin
                  mode_in = MODE_STR;
                  if (code_full < 16'h0080) begin
                     cmd_c.count   = 2'd1;
                     cmd_c.data[0] = code_full[7:0];
                  end else if (code_full < 16'h0800) begin
                     cmd_c.count   = 2'd2;
                     cmd_c.data[0] = 8'hC0 | {3'b000, code_full[10:6]};
                     cmd_c.data[1] = 8'h80 | {2'b00, code_full[5:0]};
                  end else begin
                     cmd_c.count   = 2'd3;
                     cmd_c.data[0] = 8'hE0 | {4'h0, code_full[15:12]};
                     cmd_c.data[1] = 8'h80 | {2'b00, code_full[11:6]};
                     cmd_c.data[2] = 8'h80 | {2'b00, code_full[5:0]};
                  end
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end

      // Leaving the escape sequence, by error or by completion, clears it.
      if (mode_in == MODE_IDLE || mode_in == MODE_STR) begin
         hex_cnt_in = 2'd0;
         code_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         hex_cnt_ff <= 2'd0;
         code_ff    <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
         code_ff    <= code_in;
      end
   end

   assign cmd_push = accept && (cmd_c.count != 2'd0);
   assign cmd      = cmd_c;

endmodule

`default_nettype wire

// ===== rtl/jsu_queue.sv =====
// Short command queue between the parser front end and the output sequencer.
// Depends on jsu_pkg.
`default_nettype none

module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = JSU_QUEUE_DEPTH
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  jsu_cmd_type       push_cmd,
   input  wire logic         pop,
   output jsu_cmd_type       head_cmd,
   output jsu_qstat_type     status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_cmd_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop) count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Output sequencer: walks the bytes of the head command into a registered
// result stage, one result per cycle while it is free. Depends on jsu_pkg.
`default_nettype none

module jsu_back
   import jsu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  jsu_cmd_type      head_cmd,
   input  jsu_qstat_type    q_status,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic             rsp_last_of_run
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic [1:0] kind_ff;
   logic       last_ff;
   logic       slot_free, load, is_last;

   // The result stage takes a new entry when empty or when its entry leaves now.
   assign slot_free = !valid_ff || rsp_pop;
   assign load      = slot_free && !q_status.empty;
   assign is_last   = (idx_ff == head_cmd.count - 2'd1);
   assign q_pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (slot_free) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_cmd.data[idx_ff];
         kind_ff <= head_cmd.kind;
         last_ff <= is_last;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_top.sv =====
// JSON string unescaper, top level: parser front end, command queue and
// output sequencer. Input channel: req_push/req_full carrying req_in_byte and
// req_stream_end. Result channel: rsp_empty/rsp_pop carrying rsp_out_byte,
// rsp_kind (0 data, 1 string closed, 2 parse error) and rsp_last_of_run.
// A transaction is accepted on a rising edge with push high and full low, or
// pop high and empty low. Whitespace before the opening quote is skipped.
// The first result of an input byte passes through the command queue and
// then the registered result stage. One input byte is accepted per cycle
// while req_full is low; the sequencer delivers one result per cycle while
// the result stage is free, so a \u escape that encodes to two or three
// UTF-8 bytes holds the output for one result per byte and the command queue
// (QUEUE_DEPTH entries) absorbs the input meanwhile. When the receiver stalls,
// the result stage holds its entry and the queue fills until req_full rises.
// Synchronous reset empties the queue and the result stage and returns the
// parser to waiting for an opening quote.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`default_nettype none

module json_string_unescape_top
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_stream_end,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic             rsp_last_of_run
);

   logic          accept;
   logic          cmd_push;
   jsu_cmd_type   cmd;
   jsu_cmd_type   head_cmd;
   jsu_qstat_type q_status;
   logic          q_pop;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .stream_end (req_stream_end),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result stage not empty after reset");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_cmd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (cmd.count != 2'd0 && (cmd.kind == JSU_KIND_DATA ||
                    cmd.count == 2'd1)))
      else $error("malformed command pushed");

   a_status_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != JSU_KIND_DATA) |->
         (rsp_out_byte == 8'h00 && rsp_last_of_run))
      else $error("status result carries data or is not last");

   a_pop_head_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("sequencer popped an empty queue");

endmodule

`default_nettype wire
